>>> hw/rtl/cxpc_pkg.sv
// shared types and constants for the chained xor packet cipher
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package cxpc_pkg;

  // register map, word index = paddr[3:2]
  localparam int          ADDR_W        = 4;
  localparam logic [1:0]  REG_DIRECTION = 2'd0;
  localparam logic [1:0]  REG_KEY_LOW   = 2'd1;
  localparam logic [1:0]  REG_KEY_HIGH  = 2'd2;

  // input kind codes
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_RELOAD = 1'b1;

  // direction codes
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic {
    OP_BODY   = 1'b0,
    OP_RELOAD = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> hw/rtl/chained_xor_packet_cipher_unit.sv
// path: an accepted item is written to the command queue, then popped into the output register
// throughput: one item per cycle unless out_ready holds the output; chain and key update as each item is popped
// a reload item takes one queue slot, is popped without waiting on the output, and makes no output
// reset (rst, synchronous): rolling key, chain byte, position, queue and output cleared;
// config registers reset to zero
`timescale 1ns / 1ps

module chained_xor_packet_cipher_unit (
  input  logic                             clk,
  input  logic                             rst,
  // item input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cxpc_pkg::in_item_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output cxpc_pkg::out_item_t              out_data,
  // apb-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cxpc_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import cxpc_pkg::*;

  // configuration registers
  logic        direction;
  logic [31:0] initial_key_low;
  logic [31:0] key_high;
  logic        cfg_write;
  logic [1:0]  reg_index;

  // front to back queue head and pop
  q_head_t     head;
  logic        pop;

  // zero wait state port: every access cycle completes
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction       <= DIR_ENCRYPT;
      initial_key_low <= '0;
      key_high        <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_DIRECTION: direction       <= pwdata[0];
        REG_KEY_LOW:   initial_key_low <= pwdata;
        REG_KEY_HIGH:  key_high        <= pwdata;
        default:       direction       <= direction; // unmapped word, write dropped
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      REG_DIRECTION: prdata = {31'd0, direction};
      REG_KEY_LOW:   prdata = initial_key_low;
      REG_KEY_HIGH:  prdata = key_high;
      default:       prdata = 32'd0;
    endcase
  end

  // front end: takes transfers, tags body or reload, buffers up to two commands
  cxpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // back end: xor with key byte and chain byte, rolls the low key at packet end
  cxpc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .direction       (direction),
    .initial_key_low (initial_key_low),
    .key_high        (key_high),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

>>> hw/rtl/cxpc_front.sv
// front end: accepts input transfers, classifies them and queues commands
// depends on cxpc_pkg
`timescale 1ns / 1ps

module cxpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cxpc_pkg::in_item_t in_data,
  output cxpc_pkg::q_head_t head,
  input  logic              pop
);
  import cxpc_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;
  cmd_t              cmd_in;

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count != '0);

  // classify the incoming item
  always_comb begin
    cmd_in.op   = (in_data.kind == KIND_RELOAD) ? OP_RELOAD : OP_BODY;
    cmd_in.data = in_data.data_byte;
    cmd_in.last = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

endmodule

>>> hw/rtl/cxpc_back.sv
// back end: rolling key state, chained xor datapath and output register
// depends on cxpc_pkg
`timescale 1ns / 1ps

module cxpc_back (
  input  logic               clk,
  input  logic               rst,
  input  cxpc_pkg::q_head_t  head,
  output logic               pop,
  input  logic               direction,
  input  logic [31:0]        initial_key_low,
  input  logic [31:0]        key_high,
  output logic               out_valid,
  input  logic               out_ready,
  output cxpc_pkg::out_item_t out_data
);
  import cxpc_pkg::*;

  logic [31:0] rolling_key_low;
  logic [31:0] rolling_key_low_next;
  logic [7:0]  chain_byte;
  logic [7:0]  chain_byte_next;
  logic [15:0] byte_position;
  logic [15:0] byte_position_next;
  logic [15:0] pos_inc;
  logic [31:0] key_word;
  logic [7:0]  key_byte;
  logic [7:0]  result;
  logic        out_free;
  logic        is_body;

  assign out_free = !out_valid || out_ready;
  assign is_body  = (head.cmd.op == OP_BODY);
  // reloads make no output and never wait on the output register
  assign pop      = head.valid && (!is_body || out_free);

  assign key_word = byte_position[2] ? key_high : rolling_key_low;
  assign key_byte = key_word[byte_position[1:0]*8 +: 8];
  assign result   = head.cmd.data ^ key_byte ^ chain_byte;
  assign pos_inc  = byte_position + 16'd1;

  always_comb begin
    rolling_key_low_next = rolling_key_low;
    chain_byte_next      = chain_byte;
    byte_position_next   = byte_position;
    if (pop) begin
      case (head.cmd.op)
        OP_RELOAD: begin
          rolling_key_low_next = initial_key_low;
          chain_byte_next      = 8'h00;
          byte_position_next   = 16'd0;
        end
        OP_BODY: begin
          if (head.cmd.last) begin
            rolling_key_low_next = rolling_key_low + {16'd0, pos_inc};
            chain_byte_next      = 8'h00;
            byte_position_next   = 16'd0;
          end else begin
            chain_byte_next    = (direction == DIR_DECRYPT) ? head.cmd.data : result;
            byte_position_next = pos_inc;
          end
        end
        default: begin
          rolling_key_low_next = rolling_key_low;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_key_low <= '0;
      chain_byte      <= '0;
      byte_position   <= '0;
      out_valid       <= 1'b0;
    end else begin
      rolling_key_low <= rolling_key_low_next;
      chain_byte      <= chain_byte_next;
      byte_position   <= byte_position_next;
      if (pop && is_body) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_body) begin
      out_data.out_byte <= result;
      out_data.out_last <= head.cmd.last;
    end
  end

endmodule

>>> hw/rtl/cxpc_checker.sv
// port-level checks for chained_xor_packet_cipher_unit, attached by bind
// depends on cxpc_pkg
`timescale 1ns / 1ps

module cxpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input cxpc_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input cxpc_pkg::out_item_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pready
);
  import cxpc_pkg::*;

  // body bytes taken but not yet delivered
  logic [2:0] pending;
  logic       body_in;
  logic       body_out;

  assign body_in  = in_valid && in_ready && (in_data.kind == KIND_BODY);
  assign body_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'd0, body_in} - {2'd0, body_out};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    body_out |-> pending != 3'd0)
    else $error("result transfer without a pending body byte");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more body bytes in flight than the queue and output hold");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind chained_xor_packet_cipher_unit cxpc_checker u_cxpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pready    (pready)
);

>>> dv/cipher_stream_checker.sv
// checker for the chained xor packet cipher: watches the item, result and register channels
// keeps its own copy of the cipher state, predicts each result and compares it
`timescale 1ns / 1ps

module cipher_stream_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  cxpc_pkg::in_item_t        in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  cxpc_pkg::out_item_t       out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cxpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  input  logic [31:0]               prdata,
  input  logic                      pready,
  output int                        errors,
  output int                        pending
);
  import cxpc_pkg::*;

  // register copies
  logic        dir_reg;
  logic [31:0] key_low_reg;
  logic [31:0] key_high_reg;

  // cipher state copies
  logic [31:0] rolling_low;
  logic [7:0]  chain;
  logic [15:0] position;

  out_item_t   xformed_q[$];
  out_item_t   want;
  logic [31:0] reg_value;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got_v,
                               want_v);
  endtask

  // positions 0..3 from the rolling low word, 4..7 from the fixed high word
  function automatic logic [7:0] key_byte(input logic [2:0] sel);
    logic [31:0] word;
    word = sel[2] ? key_high_reg : rolling_low;
    return word[sel[1:0]*8 +: 8];
  endfunction

  task automatic transform_byte(input in_item_t it);
    out_item_t res;
    res.out_byte = it.data_byte ^ key_byte(position[2:0]) ^ chain;
    res.out_last = it.last;
    chain = (dir_reg == DIR_DECRYPT) ? it.data_byte : res.out_byte;
    position = position + 16'd1;
    if (it.last) begin
      rolling_low = rolling_low + {16'd0, position};
      chain = 8'd0;
      position = 16'd0;
    end
    xformed_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dir_reg = DIR_ENCRYPT;
      key_low_reg = 32'd0;
      key_high_reg = 32'd0;
      rolling_low = 32'd0;
      chain = 8'd0;
      position = 16'd0;
      xformed_q.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_DIRECTION: dir_reg = pwdata[0];
            REG_KEY_LOW:   key_low_reg = pwdata;
            REG_KEY_HIGH:  key_high_reg = pwdata;
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_DIRECTION: reg_value = {31'd0, dir_reg};
            REG_KEY_LOW:   reg_value = key_low_reg;
            REG_KEY_HIGH:  reg_value = key_high_reg;
            default:       reg_value = prdata;
          endcase
          if (prdata !== reg_value) report_mismatch("register read", prdata, reg_value);
        end
      end
      // result transfer
      if (out_valid && out_ready) begin
        if (xformed_q.size() == 0) begin
          report_mismatch("result with nothing pending", {23'd0, out_data}, 32'd0);
        end else begin
          want = xformed_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", {24'd0, out_data.out_byte}, {24'd0, want.out_byte});
          if (out_data.out_last !== want.out_last)
            report_mismatch("out_last", {31'd0, out_data.out_last}, {31'd0, want.out_last});
        end
      end
      // item transfer
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_RELOAD) begin
          rolling_low = key_low_reg;
          chain = 8'd0;
          position = 16'd0;
        end else begin
          transform_byte(in_data);
        end
      end
    end
    pending = xformed_q.size();
  end

endmodule

>>> dv/chained_xor_packet_cipher_unit_tb.sv
// testbench top for chained_xor_packet_cipher_unit: drives items, results ready and registers
// depends on cxpc_pkg, the block and cipher_stream_checker, which does all prediction
`timescale 1ns / 1ps

module chained_xor_packet_cipher_unit_tb;
  import cxpc_pkg::*;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int                  chk_errors;
  int                  pending;

  // stimulus bookkeeping
  bit                  quiet = 1'b0;   // no idling on either side while set
  int                  stuck = 0;
  int                  n_bytes = 0;
  int                  n_packets = 0;
  int                  n_reloads = 0;
  int                  n_writes = 0;
  logic                cur_dir = DIR_ENCRYPT;

  chained_xor_packet_cipher_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  cipher_stream_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .errors    (chk_errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: out_ready drawn low with a chance of 27 in a hundred unless quiet
  initial begin
    forever begin
      @(negedge clk);
      out_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 27);
    end
  end

  // one item transfer; called at a falling edge, returns at a falling edge
  // valid stays high into the next item when no idle cycle is rolled
  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_body(input logic [7:0] b, input logic is_last);
    in_item_t it;
    it.kind = KIND_BODY;
    it.data_byte = b;
    it.last = is_last;
    send_item(it);
    n_bytes++;
    if (is_last) n_packets++;
  endtask

  // data and last are don't-care on a reload, so they get random values
  task automatic send_reload();
    in_item_t it;
    it.kind = KIND_RELOAD;
    it.data_byte = 8'($urandom);
    it.last = 1'($urandom);
    send_item(it);
    n_reloads++;
  endtask

  // random body bytes; last only on the final one when closed is set
  task automatic send_bytes(input int len, input bit closed);
    for (int i = 0; i < len; i++) send_body(8'($urandom), closed && (i == len - 1));
  endtask

  // drop valid, wait until every result is back (counting a stuck run if not), then idle for the given tail
  task automatic drain(input int tail);
    int waited;
    waited = 0;
    in_valid = 1'b0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) stuck++;
    repeat (tail) @(negedge clk);
  endtask

  // apb access: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // write then read back; the checker compares the read data
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
    apb_access(1'b1, idx, v);
    apb_access(1'b0, idx, 32'd0);
    if (idx == REG_DIRECTION) cur_dir = v[0];
    n_writes++;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'hffff_fff0 | 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int left;
    int len;
    int cut;

    // reset
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // reset config: zero key, encrypt, chaining on output alone
    send_body(8'h00, 1'b0);
    send_body(8'hff, 1'b1);
    drain(4);
    cfg_write(REG_KEY_LOW, 32'h3322_1100);
    cfg_write(REG_KEY_HIGH, 32'h7766_5544);
    // reload carrying last high and a full data byte, both ignored
    in_data = '0;
    send_item('{kind: KIND_RELOAD, data_byte: 8'hff, last: 1'b1});
    n_reloads++;
    // nine bytes walk all eight key positions and wrap once
    for (int i = 0; i < 9; i++) send_body(8'(i * 17), i == 8);
    // single-byte packet sees the low key advanced by nine
    send_body(8'h5a, 1'b1);
    drain(4);
    // decrypt: chaining on input
    cfg_write(REG_DIRECTION, {31'd0, DIR_DECRYPT});
    send_body(8'hff, 1'b0);
    send_body(8'h00, 1'b1);
    // direction flips in the middle of a packet
    send_body(8'h3c, 1'b0);
    send_body(8'hc3, 1'b0);
    drain(4);
    cfg_write(REG_DIRECTION, {31'd0, DIR_ENCRYPT});
    send_body(8'h81, 1'b0);
    send_body(8'h7e, 1'b1);
    // reload abandons a packet in progress
    send_body(8'h11, 1'b0);
    send_body(8'h22, 1'b0);
    send_reload();
    drain(4);
    // all-ones keys, low key add wraps past 2^32
    cfg_write(REG_KEY_LOW, 32'hffff_ffff);
    cfg_write(REG_KEY_HIGH, 32'hffff_ffff);
    send_reload();
    send_body(8'haa, 1'b0);
    send_body(8'h55, 1'b1);
    send_body(8'h0f, 1'b1);
    send_bytes(5, 1'b1);
    drain(4);

    // ---- random part ----
    for (int phase = 0; phase < 8; phase++) begin
      drain(4);
      quiet = (phase == 3);
      // new settings between phases, extremes mixed in
      if (phase == 0 || $urandom_range(0, 1)) cfg_write(REG_DIRECTION, 32'($urandom_range(0, 1)));
      if (phase == 0 || $urandom_range(0, 2)) cfg_write(REG_KEY_LOW, pick_key());
      if (phase == 0 || $urandom_range(0, 2)) cfg_write(REG_KEY_HIGH, pick_key());
      if ($urandom_range(0, 3) != 0) send_reload();
      left = 130;
      while (left > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        case ($urandom_range(0, 99)) inside
          [0:3]: begin
            // stray reload
            send_reload();
            left--;
          end
          [4:7]: begin
            // broken packet cut short by a reload
            cut = $urandom_range(1, len);
            send_bytes(cut, 1'b0);
            send_reload();
            left -= cut;
          end
          [8:10]: begin
            // direction flipped while the packet is open
            cut = $urandom_range(1, len);
            send_bytes(cut, 1'b0);
            drain(4);
            cfg_write(REG_DIRECTION, {31'd0, ~cur_dir});
            send_bytes(len - cut + 1, 1'b1);
            left -= len + 1;
          end
          default: begin
            send_bytes(len, 1'b1);
            left -= len;
          end
        endcase
      end
    end
    quiet = 1'b0;

    // ---- wrap up ----
    drain(8);
    $display("covered %0d body bytes in %0d packets, %0d key reloads, %0d register writes",
             n_bytes, n_packets, n_reloads, n_writes);
    if (chk_errors == 0 && stuck == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
